// ----- rtl/gbu_pkg.sv -----
// Shared types and constants for the bilinear upsampling and classification unit.
package gbu_pkg;

    localparam int FRAC_BITS = 16;
    localparam int HEIGHT_W  = 20;
    localparam int CLASS_W   = 2;
    localparam int FINE_W    = 9;
    localparam int COORD_W   = 5;
    localparam int SAMPLE_W  = 5;
    localparam int CFG_IW    = 3;
    localparam int CFG_DW    = 10;
    localparam int GAP_W     = 5;
    localparam int LEVEL_W   = 10;
    localparam int RQ_SHIFT  = 16;
    localparam int RQ_W      = 17;
    localparam int RS_SHIFT  = 27;
    localparam int RS_W      = 28;

    typedef enum logic [CFG_IW-1:0] {
        CFG_GAP  = 3'd0,
        CFG_COLS = 3'd1,
        CFG_ROWS = 3'd2,
        CFG_LOW  = 3'd3,
        CFG_HIGH = 3'd4
    } t_cfg_idx;

    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    localparam logic [CLASS_W-1:0] CLS_ZERO = 2'd0;
    localparam logic [CLASS_W-1:0] CLS_LOW  = 2'd1;
    localparam logic [CLASS_W-1:0] CLS_MID  = 2'd2;
    localparam logic [CLASS_W-1:0] CLS_HIGH = 2'd3;

    localparam logic ST_OK    = 1'b0;
    localparam logic ST_RANGE = 1'b1;

endpackage

// ----- rtl/grid_bilinear_upsample_classify_unit.sv -----
// Top level of the bilinear upsampling and texture classification unit.
//
// Beats arrive on the command channel: an item is taken on each rising edge
// with start high and busy low. busy is always low, so one beat per cycle is
// accepted. A write beat (req_type 0) stores one coarse sample and gives no
// result. A query beat (req_type 1) gives exactly one result beat, shown
// for one cycle with o_result_valid high. The pipeline has nine stages
// (input register, coordinate split, store read, row steps, row values,
// column step in two halves, column value, classification); throughput
// is one beat per cycle.
// The coarse store is four copies of one RAM so that the four corner samples
// are read in one cycle; writes go to all copies in the same stage as reads,
// so a query sees every write accepted before it.
// Configuration beats use their own valid/ready channel, which is always
// ready, and are to be sent only while no query is in flight.
// Synchronous reset clears the pipeline valid bits and restores the
// configuration registers; the store keeps undefined contents until written.
// The receiver cannot stall, so no result is ever held back.
module grid_bilinear_upsample_classify_unit #(
    parameter int MAX_COARSE_X = 16,
    parameter int MAX_COARSE_Y = 16,
    parameter int MAX_GAP      = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic                               i_req_type,
    input  logic [gbu_pkg::COORD_W-1:0]        i_coarse_x,
    input  logic [gbu_pkg::COORD_W-1:0]        i_coarse_y,
    input  logic signed [gbu_pkg::SAMPLE_W-1:0] i_sample,
    input  logic [gbu_pkg::FINE_W-1:0]         i_fine_x,
    input  logic [gbu_pkg::FINE_W-1:0]         i_fine_y,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [gbu_pkg::CFG_IW-1:0]         i_cfg_index,
    input  logic [gbu_pkg::CFG_DW-1:0]         i_cfg_data,
    output logic                               o_result_valid,
    output logic [gbu_pkg::HEIGHT_W-1:0]       o_height,
    output logic [gbu_pkg::CLASS_W-1:0]        o_texture_class,
    output logic                               o_status
);
    import gbu_pkg::*;

    localparam int GW     = $clog2(MAX_GAP + 1);
    localparam int XW     = $clog2(MAX_COARSE_X + 1);
    localparam int YW     = $clog2(MAX_COARSE_Y + 1);
    localparam int STRIDE = MAX_COARSE_X + 1;
    localparam int DEPTH  = STRIDE * (MAX_COARSE_Y + 1);
    localparam int AW     = $clog2(DEPTH);

    logic [GAP_W-1:0]   r_gap;
    logic [GAP_W-1:0]   r_cols;
    logic [GAP_W-1:0]   r_rows;
    logic [LEVEL_W-1:0] r_low;
    logic [LEVEL_W-1:0] r_high;

    logic [GW-1:0] w_g;
    logic [XW-1:0] w_cols;
    logic [YW-1:0] w_rows;

    logic [RQ_W-1:0] w_rq [1:MAX_GAP];
    logic [RS_W-1:0] w_rs [1:MAX_GAP];
    logic [RQ_W-1:0] w_rq_g;
    logic [RS_W-1:0] w_rs_g;

    for (genvar gi = 1; gi <= MAX_GAP; gi++) begin : g_recip
        localparam longint RQ = ((64'd1 << RQ_SHIFT) + gi - 1) / gi;
        localparam longint RS = ((64'd1 << RS_SHIFT) + gi - 1) / gi;
        assign w_rq[gi] = RQ_W'(RQ);
        assign w_rs[gi] = RS_W'(RS);
    end

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gap  <= GAP_W'(4);
            r_cols <= GAP_W'(8);
            r_rows <= GAP_W'(8);
            r_low  <= LEVEL_W'(50);
            r_high <= LEVEL_W'(400);
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_GAP:  r_gap  <= i_cfg_data[GAP_W-1:0];
                CFG_COLS: r_cols <= i_cfg_data[GAP_W-1:0];
                CFG_ROWS: r_rows <= i_cfg_data[GAP_W-1:0];
                CFG_LOW:  r_low  <= i_cfg_data;
                CFG_HIGH: r_high <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        if (r_gap == '0) begin
            w_g = GW'(1);
        end else if (32'(r_gap) > MAX_GAP) begin
            w_g = GW'(MAX_GAP);
        end else begin
            w_g = GW'(r_gap);
        end
        if (r_cols == '0) begin
            w_cols = XW'(1);
        end else if (32'(r_cols) > MAX_COARSE_X) begin
            w_cols = XW'(MAX_COARSE_X);
        end else begin
            w_cols = XW'(r_cols);
        end
        if (r_rows == '0) begin
            w_rows = YW'(1);
        end else if (32'(r_rows) > MAX_COARSE_Y) begin
            w_rows = YW'(MAX_COARSE_Y);
        end else begin
            w_rows = YW'(r_rows);
        end
    end

    assign w_rq_g = w_rq[w_g];
    assign w_rs_g = w_rs[w_g];

    // Stage 1: input register.
    logic                      r_s1_v;
    logic                      r_s1_type;
    logic [COORD_W-1:0]        r_s1_wx;
    logic [COORD_W-1:0]        r_s1_wy;
    logic [SAMPLE_W-1:0]       r_s1_smp;
    logic [FINE_W-1:0]         r_s1_fx;
    logic [FINE_W-1:0]         r_s1_fy;

    // Stage 2: quotients and range check.
    logic                      r_s2_v;
    logic                      r_s2_type;
    logic                      r_s2_wok;
    logic                      r_s2_oor;
    logic [COORD_W-1:0]        r_s2_wx;
    logic [COORD_W-1:0]        r_s2_wy;
    logic [SAMPLE_W-1:0]       r_s2_smp;
    logic [FINE_W-1:0]         r_s2_fx;
    logic [FINE_W-1:0]         r_s2_fy;
    logic [FINE_W-1:0]         r_s2_qx;
    logic [FINE_W-1:0]         r_s2_qy;

    logic [FINE_W+RQ_W-1:0]    n_px;
    logic [FINE_W+RQ_W-1:0]    n_py;
    logic [15:0]               n_limx;
    logic [15:0]               n_limy;

    assign n_px   = (FINE_W+RQ_W)'(r_s1_fx) * (FINE_W+RQ_W)'(w_rq_g);
    assign n_py   = (FINE_W+RQ_W)'(r_s1_fy) * (FINE_W+RQ_W)'(w_rq_g);
    assign n_limx = 16'(w_g) * 16'(w_cols);
    assign n_limy = 16'(w_g) * 16'(w_rows);

    // Stage 3: offsets and store access.
    logic [15:0]  n_mx;
    logic [15:0]  n_my;
    logic [GW-1:0] n_ox;
    logic [GW-1:0] n_oy;
    logic [XW-1:0] n_cx;
    logic [XW-1:0] n_cx1;
    logic [YW-1:0] n_cy;
    logic [YW-1:0] n_cy1;
    logic [AW-1:0] n_ra00;
    logic [AW-1:0] n_ra01;
    logic [AW-1:0] n_ra10;
    logic [AW-1:0] n_ra11;
    logic [AW-1:0] n_wa;
    logic          n_we;

    assign n_mx  = 16'(r_s2_qx) * 16'(w_g);
    assign n_my  = 16'(r_s2_qy) * 16'(w_g);
    assign n_ox  = GW'(16'(r_s2_fx) - n_mx);
    assign n_oy  = GW'(16'(r_s2_fy) - n_my);
    assign n_cx  = XW'(r_s2_qx);
    assign n_cy  = YW'(r_s2_qy);
    assign n_cx1 = (n_ox != '0) ? n_cx + XW'(1) : n_cx;
    assign n_cy1 = (n_oy != '0) ? n_cy + YW'(1) : n_cy;
    assign n_ra00 = AW'(32'(n_cy) * STRIDE + 32'(n_cx));
    assign n_ra01 = AW'(32'(n_cy) * STRIDE + 32'(n_cx1));
    assign n_ra10 = AW'(32'(n_cy1) * STRIDE + 32'(n_cx));
    assign n_ra11 = AW'(32'(n_cy1) * STRIDE + 32'(n_cx1));
    assign n_wa   = AW'(32'(r_s2_wy) * STRIDE + 32'(r_s2_wx));
    assign n_we   = r_s2_v && (r_s2_type == REQ_WRITE) && r_s2_wok;

    logic [SAMPLE_W-1:0] w_a00;
    logic [SAMPLE_W-1:0] w_a01;
    logic [SAMPLE_W-1:0] w_a10;
    logic [SAMPLE_W-1:0] w_a11;

    gbu_ram #(.WIDTH(SAMPLE_W), .DEPTH(DEPTH)) u_ram00 (
        .i_clk(i_clk), .i_we(n_we), .i_waddr(n_wa), .i_wdata(r_s2_smp),
        .i_raddr(n_ra00), .o_rdata(w_a00)
    );
    gbu_ram #(.WIDTH(SAMPLE_W), .DEPTH(DEPTH)) u_ram01 (
        .i_clk(i_clk), .i_we(n_we), .i_waddr(n_wa), .i_wdata(r_s2_smp),
        .i_raddr(n_ra01), .o_rdata(w_a01)
    );
    gbu_ram #(.WIDTH(SAMPLE_W), .DEPTH(DEPTH)) u_ram10 (
        .i_clk(i_clk), .i_we(n_we), .i_waddr(n_wa), .i_wdata(r_s2_smp),
        .i_raddr(n_ra10), .o_rdata(w_a10)
    );
    gbu_ram #(.WIDTH(SAMPLE_W), .DEPTH(DEPTH)) u_ram11 (
        .i_clk(i_clk), .i_we(n_we), .i_waddr(n_wa), .i_wdata(r_s2_smp),
        .i_raddr(n_ra11), .o_rdata(w_a11)
    );

    logic          r_s3_v;
    logic          r_s3_oor;
    logic [GW-1:0] r_s3_ox;
    logic [GW-1:0] r_s3_oy;

    // Stage 4: row step magnitudes.
    logic signed [SAMPLE_W:0] n_d0;
    logic signed [SAMPLE_W:0] n_d1;
    logic [SAMPLE_W:0]        n_m0;
    logic [SAMPLE_W:0]        n_m1;
    logic [32:0]              n_p0;
    logic [32:0]              n_p1;

    assign n_d0 = $signed({w_a01[SAMPLE_W-1], w_a01}) - $signed({w_a00[SAMPLE_W-1], w_a00});
    assign n_d1 = $signed({w_a11[SAMPLE_W-1], w_a11}) - $signed({w_a10[SAMPLE_W-1], w_a10});
    assign n_m0 = n_d0[SAMPLE_W] ? 6'(-n_d0) : 6'(n_d0);
    assign n_m1 = n_d1[SAMPLE_W] ? 6'(-n_d1) : 6'(n_d1);
    assign n_p0 = 33'(n_m0[SAMPLE_W-1:0]) * 33'(w_rs_g);
    assign n_p1 = 33'(n_m1[SAMPLE_W-1:0]) * 33'(w_rs_g);

    logic                r_s4_v;
    logic                r_s4_oor;
    logic [GW-1:0]       r_s4_ox;
    logic [GW-1:0]       r_s4_oy;
    logic [20:0]         r_s4_st0;
    logic [20:0]         r_s4_st1;
    logic                r_s4_sg0;
    logic                r_s4_sg1;
    logic [SAMPLE_W-1:0] r_s4_a0;
    logic [SAMPLE_W-1:0] r_s4_a1;

    // Stage 5: row values.
    logic [20+GW:0]    n_q0;
    logic [20+GW:0]    n_q1;
    logic signed [22:0] n_b0;
    logic signed [22:0] n_b1;
    logic signed [22:0] n_v0;
    logic signed [22:0] n_v1;

    assign n_q0 = (21+GW)'(r_s4_st0) * (21+GW)'(r_s4_ox);
    assign n_q1 = (21+GW)'(r_s4_st1) * (21+GW)'(r_s4_ox);
    assign n_b0 = $signed({{2{r_s4_a0[SAMPLE_W-1]}}, r_s4_a0, 16'b0});
    assign n_b1 = $signed({{2{r_s4_a1[SAMPLE_W-1]}}, r_s4_a1, 16'b0});
    assign n_v0 = r_s4_sg0 ? n_b0 - $signed({2'b0, n_q0[20:0]})
                           : n_b0 + $signed({2'b0, n_q0[20:0]});
    assign n_v1 = r_s4_sg1 ? n_b1 - $signed({2'b0, n_q1[20:0]})
                           : n_b1 + $signed({2'b0, n_q1[20:0]});

    logic               r_s5_v;
    logic               r_s5_oor;
    logic [GW-1:0]      r_s5_oy;
    logic signed [22:0] r_s5_v0;
    logic signed [22:0] r_s5_v1;

    // Stage 6: column step, split into two partial products.
    logic signed [22:0] n_dv;
    logic [22:0]        n_mv;
    logic [37:0]        n_ph;
    logic [38:0]        n_pl;

    assign n_dv = r_s5_v1 - r_s5_v0;
    assign n_mv = n_dv[22] ? 23'(-n_dv) : 23'(n_dv);
    assign n_ph = 38'(n_mv[20:11]) * 38'(w_rs_g);
    assign n_pl = 39'(n_mv[10:0]) * 39'(w_rs_g);

    logic               r_s6_v;
    logic               r_s6_oor;
    logic [GW-1:0]      r_s6_oy;
    logic               r_s6_sg;
    logic signed [22:0] r_s6_v0;
    logic [37:0]        r_s6_ph;
    logic [38:0]        r_s6_pl;

    // Stage 7: column step sum.
    logic [49:0] n_ps;
    assign n_ps = {1'b0, r_s6_ph, 11'b0} + 50'(r_s6_pl);

    logic               r_s7_v;
    logic               r_s7_oor;
    logic [GW-1:0]      r_s7_oy;
    logic               r_s7_sg;
    logic signed [22:0] r_s7_v0;
    logic [20:0]        r_s7_st;

    // Stage 8: column value.
    logic [20+GW:0]     n_qc;
    logic signed [22:0] n_h;

    assign n_qc = (21+GW)'(r_s7_st) * (21+GW)'(r_s7_oy);
    assign n_h  = r_s7_sg ? r_s7_v0 - $signed({2'b0, n_qc[20:0]})
                          : r_s7_v0 + $signed({2'b0, n_qc[20:0]});

    logic               r_s8_v;
    logic               r_s8_oor;
    logic signed [22:0] r_s8_h;

    // Stage 9: clamp and classification.
    logic [HEIGHT_W-1:0] n_height;
    logic [CLASS_W-1:0]  n_class;
    logic                n_status;
    logic [25:0]         n_hu;

    assign n_hu = 26'(r_s8_h[21:0]);

    always_comb begin
        n_height = '0;
        n_class  = CLS_ZERO;
        n_status = ST_OK;
        if (r_s8_oor) begin
            n_status = ST_RANGE;
        end else if (r_s8_h <= 0) begin
            n_class = CLS_ZERO;
        end else begin
            n_height = r_s8_h[HEIGHT_W-1:0];
            if (n_hu <= {r_low, 16'b0}) begin
                n_class = CLS_LOW;
            end else if (n_hu <= {r_high, 16'b0}) begin
                n_class = CLS_MID;
            end else begin
                n_class = CLS_HIGH;
            end
        end
    end

    logic                r_out_v;
    logic [HEIGHT_W-1:0] r_out_height;
    logic [CLASS_W-1:0]  r_out_class;
    logic                r_out_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v  <= 1'b0;
            r_s2_v  <= 1'b0;
            r_s3_v  <= 1'b0;
            r_s4_v  <= 1'b0;
            r_s5_v  <= 1'b0;
            r_s6_v  <= 1'b0;
            r_s7_v  <= 1'b0;
            r_s8_v  <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            r_s1_v  <= start && !busy;
            r_s2_v  <= r_s1_v;
            r_s3_v  <= r_s2_v && (r_s2_type == REQ_QUERY);
            r_s4_v  <= r_s3_v;
            r_s5_v  <= r_s4_v;
            r_s6_v  <= r_s5_v;
            r_s7_v  <= r_s6_v;
            r_s8_v  <= r_s7_v;
            r_out_v <= r_s8_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_type <= i_req_type;
        r_s1_wx   <= i_coarse_x;
        r_s1_wy   <= i_coarse_y;
        r_s1_smp  <= i_sample;
        r_s1_fx   <= i_fine_x;
        r_s1_fy   <= i_fine_y;

        r_s2_type <= r_s1_type;
        r_s2_wok  <= (32'(r_s1_wx) <= MAX_COARSE_X) && (32'(r_s1_wy) <= MAX_COARSE_Y);
        r_s2_oor  <= (16'(r_s1_fx) > n_limx) || (16'(r_s1_fy) > n_limy);
        r_s2_wx   <= r_s1_wx;
        r_s2_wy   <= r_s1_wy;
        r_s2_smp  <= r_s1_smp;
        r_s2_fx   <= r_s1_fx;
        r_s2_fy   <= r_s1_fy;
        r_s2_qx   <= n_px[RQ_SHIFT+FINE_W-1:RQ_SHIFT];
        r_s2_qy   <= n_py[RQ_SHIFT+FINE_W-1:RQ_SHIFT];

        r_s3_oor  <= r_s2_oor;
        r_s3_ox   <= n_ox;
        r_s3_oy   <= n_oy;

        r_s4_oor  <= r_s3_oor;
        r_s4_ox   <= r_s3_ox;
        r_s4_oy   <= r_s3_oy;
        r_s4_st0  <= n_p0[31:11];
        r_s4_st1  <= n_p1[31:11];
        r_s4_sg0  <= n_d0[SAMPLE_W];
        r_s4_sg1  <= n_d1[SAMPLE_W];
        r_s4_a0   <= w_a00;
        r_s4_a1   <= w_a10;

        r_s5_oor  <= r_s4_oor;
        r_s5_oy   <= r_s4_oy;
        r_s5_v0   <= n_v0;
        r_s5_v1   <= n_v1;

        r_s6_oor  <= r_s5_oor;
        r_s6_oy   <= r_s5_oy;
        r_s6_sg   <= n_dv[22];
        r_s6_v0   <= r_s5_v0;
        r_s6_ph   <= n_ph;
        r_s6_pl   <= n_pl;

        r_s7_oor  <= r_s6_oor;
        r_s7_oy   <= r_s6_oy;
        r_s7_sg   <= r_s6_sg;
        r_s7_v0   <= r_s6_v0;
        r_s7_st   <= n_ps[RS_SHIFT+20:RS_SHIFT];

        r_s8_oor  <= r_s7_oor;
        r_s8_h    <= n_h;

        r_out_height <= n_height;
        r_out_class  <= n_class;
        r_out_status <= n_status;
    end

    assign o_result_valid  = r_out_v;
    assign o_height        = r_out_height;
    assign o_texture_class = r_out_class;
    assign o_status        = r_out_status;
endmodule

// ----- rtl/gbu_ram.sv -----
// Generic single write port, single read port RAM with registered read data.
module gbu_ram #(
    parameter int WIDTH = 5,
    parameter int DEPTH = 289
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ----- bench/grid_bilinear_upsample_classify_unit_tb.sv -----
// Self-checking testbench for the bilinear upsampling and classification unit.
`timescale 1ns / 100ps

module grid_bilinear_upsample_classify_unit_tb;
    import gbu_pkg::*;

    localparam int GRID_MAX  = 16;
    localparam int GAP_MAX   = 16;
    localparam int Q_ONE     = 65536;
    localparam int SETTLE    = 12;
    localparam int CYCLE_CAP = 200000;

    typedef struct {
        logic [HEIGHT_W-1:0] height;
        logic [CLASS_W-1:0]  cls;
        logic                status;
    } t_pixel;

    class upsample_scoreboard;
        logic [SAMPLE_W-1:0] heights[GRID_MAX+1][GRID_MAX+1];
        logic [GAP_W-1:0]    gap, cols, rows;
        logic [LEVEL_W-1:0]  lvl_low, lvl_high;
        t_pixel              pending[$];
        int                  mismatches;

        function new();
            gap = 4; cols = 8; rows = 8; lvl_low = 50; lvl_high = 400;
            mismatches = 0;
        endfunction

        function void set_reg(t_cfg_idx idx, logic [CFG_DW-1:0] data);
            case (idx)
                CFG_GAP:  gap = data[GAP_W-1:0];
                CFG_COLS: cols = data[GAP_W-1:0];
                CFG_ROWS: rows = data[GAP_W-1:0];
                CFG_LOW:  lvl_low = data;
                CFG_HIGH: lvl_high = data;
                default: ;
            endcase
        endfunction

        function int clamp(int v, int hi);
            if (v < 1) return 1;
            if (v > hi) return hi;
            return v;
        endfunction

        function longint corner(int x, int y);
            return longint'($signed(heights[y][x])) * Q_ONE;
        endfunction

        function longint lerp(longint a, longint b, int g, int off);
            return a + ((b - a) / g) * off;
        endfunction

        function longint row_height(int cy, int cx, int ox, int g);
            if (ox == 0) return corner(cx, cy);
            return lerp(corner(cx, cy), corner(cx + 1, cy), g, ox);
        endfunction

        function void note_item(logic rq, logic [COORD_W-1:0] cx, logic [COORD_W-1:0] cy,
                                logic [SAMPLE_W-1:0] smp, logic [FINE_W-1:0] fx,
                                logic [FINE_W-1:0] fy);
            int g, nc, nr, ox, oy;
            longint h;
            t_pixel p;
            if (rq == REQ_WRITE) begin
                if (cx <= GRID_MAX && cy <= GRID_MAX) heights[cy][cx] = smp;
                return;
            end
            g = clamp(gap, GAP_MAX);
            nc = clamp(cols, GRID_MAX);
            nr = clamp(rows, GRID_MAX);
            if (fx > g * nc || fy > g * nr) begin
                p.height = '0; p.cls = CLS_ZERO; p.status = ST_RANGE;
            end else begin
                ox = fx % g;
                oy = fy % g;
                h = row_height(fy / g, fx / g, ox, g);
                if (oy != 0) h = lerp(h, row_height(fy / g + 1, fx / g, ox, g), g, oy);
                p.status = ST_OK;
                if (h <= 0) begin
                    h = 0; p.cls = CLS_ZERO;
                end else if (h <= longint'(lvl_low) * Q_ONE) begin
                    p.cls = CLS_LOW;
                end else if (h <= longint'(lvl_high) * Q_ONE) begin
                    p.cls = CLS_MID;
                end else begin
                    p.cls = CLS_HIGH;
                end
                p.height = h[HEIGHT_W-1:0];
            end
            pending.push_back(p);
        endfunction

        function void check(logic [HEIGHT_W-1:0] h, logic [CLASS_W-1:0] c, logic s);
            t_pixel p;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result beat: h=%0d c=%0d s=%0d",
                                               h, c, s);
                return;
            end
            p = pending.pop_front();
            if (h !== p.height || c !== p.cls || s !== p.status) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: expected h=%0d c=%0d s=%0d, got h=%0d c=%0d s=%0d",
                             p.height, p.cls, p.status, h, c, s);
            end
        endfunction
    endclass

    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       start = 1'b0;
    logic                       busy;
    logic                       i_req_type = 1'b0;
    logic [COORD_W-1:0]         i_coarse_x = '0;
    logic [COORD_W-1:0]         i_coarse_y = '0;
    logic signed [SAMPLE_W-1:0] i_sample = '0;
    logic [FINE_W-1:0]          i_fine_x = '0;
    logic [FINE_W-1:0]          i_fine_y = '0;
    logic                       i_cfg_valid = 1'b0;
    logic                       o_cfg_ready;
    logic [CFG_IW-1:0]          i_cfg_index = '0;
    logic [CFG_DW-1:0]          i_cfg_data = '0;
    logic                       o_result_valid;
    logic [HEIGHT_W-1:0]        o_height;
    logic [CLASS_W-1:0]         o_texture_class;
    logic                       o_status;

    upsample_scoreboard sb = new();
    bit  steady = 1'b0;
    int  cycles = 0;

    grid_bilinear_upsample_classify_unit i_dut (.*);

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP) begin
            $display("grid_bilinear_upsample_classify_unit verification failed");
            $finish;
        end
    end

    always @(posedge i_clk)
        if (i_rst_n && o_result_valid) sb.check(o_height, o_texture_class, o_status);

    task automatic send_beat(logic rq, logic [COORD_W-1:0] cx, logic [COORD_W-1:0] cy,
                             logic [SAMPLE_W-1:0] smp, logic [FINE_W-1:0] fx,
                             logic [FINE_W-1:0] fy);
        if (!steady && $urandom_range(99) < 7) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        start <= 1'b1;
        i_req_type <= rq;
        i_coarse_x <= cx;
        i_coarse_y <= cy;
        i_sample <= smp;
        i_fine_x <= fx;
        i_fine_y <= fy;
        do @(posedge i_clk); while (busy);
        sb.note_item(rq, cx, cy, smp, fx, fy);
    endtask

    task automatic store_sample(int x, int y, int v);
        send_beat(REQ_WRITE, COORD_W'(x), COORD_W'(y), SAMPLE_W'(v),
                  FINE_W'($urandom), FINE_W'($urandom));
    endtask

    task automatic query(int fx, int fy);
        send_beat(REQ_QUERY, COORD_W'($urandom), COORD_W'($urandom), SAMPLE_W'($urandom),
                  FINE_W'(fx), FINE_W'(fy));
    endtask

    task automatic drain();
        start <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic set_reg(t_cfg_idx idx, int data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= CFG_DW'(data);
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.set_reg(idx, CFG_DW'(data));
    endtask

    task automatic apply_settings(int g, int c, int r, int lo, int hi);
        drain();
        set_reg(CFG_GAP, g);
        set_reg(CFG_COLS, c);
        set_reg(CFG_ROWS, r);
        set_reg(CFG_LOW, lo);
        set_reg(CFG_HIGH, hi);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic int span_x();
        return sb.clamp(sb.gap, GAP_MAX) * sb.clamp(sb.cols, GRID_MAX);
    endfunction

    function automatic int span_y();
        return sb.clamp(sb.gap, GAP_MAX) * sb.clamp(sb.rows, GRID_MAX);
    endfunction

    task automatic random_phase(int n);
        int pick;
        repeat (n) begin
            pick = $urandom_range(99);
            if (pick < 18)
                store_sample($urandom_range(GRID_MAX), $urandom_range(GRID_MAX), $urandom);
            else if (pick < 22)
                store_sample($urandom_range(31), $urandom_range(31), $urandom);
            else if (pick < 30)
                query($urandom_range(511), $urandom_range(511));
            else if (pick < 40)
                query(span_x(), $urandom_range(span_y()));
            else
                query($urandom_range(span_x()), $urandom_range(span_y()));
        end
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int y = 0; y <= GRID_MAX; y++)
            for (int x = 0; x <= GRID_MAX; x++)
                store_sample(x, y, $urandom);

        store_sample(0, 0, -16);
        store_sample(1, 0, 15);
        store_sample(0, 1, 15);
        store_sample(1, 1, -16);
        store_sample(17, 3, 7);
        store_sample(31, 31, 7);
        query(0, 0);
        query(2, 0);
        query(0, 2);
        query(3, 3);
        query(32, 32);
        query(32, 5);
        query(33, 0);
        query(0, 33);
        query(511, 511);
        apply_settings(1, 16, 16, 3, 8);
        query(16, 16);
        query(17, 0);
        query(1, 1);
        apply_settings(16, 16, 16, 0, 0);
        query(256, 256);
        query(255, 255);
        query(257, 256);
        query(8, 8);

        apply_settings(4, 8, 8, 50, 400);
        random_phase(220);
        apply_settings(3, 5, 7, 2, 6);
        steady = 1'b1;
        random_phase(220);
        steady = 1'b0;
        apply_settings(0, 0, 0, 1023, 1023);
        random_phase(160);
        apply_settings(31, 31, 31, 9, 4);
        random_phase(200);
        apply_settings(7, 3, 12, 1, 12);
        random_phase(260);
        apply_settings(5, 16, 1, 4, 1023);
        random_phase(240);

        drain();
        if (sb.mismatches == 0) begin
            $display("grid_bilinear_upsample_classify_unit verification clean");
        end else begin
            $display("grid_bilinear_upsample_classify_unit verification failed");
        end
        $finish;
    end
endmodule

// ----- filelist.f -----
rtl/gbu_pkg.sv
rtl/gbu_ram.sv
rtl/grid_bilinear_upsample_classify_unit.sv
bench/grid_bilinear_upsample_classify_unit_tb.sv
